### src/svt_pkg.sv
// Shared types and constants for the sorted value table.
`timescale 1ns / 1ps

package svt_pkg;

    localparam int REQ_W    = 2;
    localparam int KEY_W    = 32;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 7;

    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_LOOKUP = 2'd2
    } req_kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE      = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SEARCH,
        S_COMPARE,
        S_ACT,
        S_INS_RD,
        S_INS_WR,
        S_REM_RD,
        S_REM_WR,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [REQ_W-1:0]        req_type;
        logic signed [KEY_W-1:0] key_value;
    } req_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                found;
        logic [POS_W-1:0]    position;
        logic [POS_W-1:0]    entry_count;
    } rsp_item_t;

endpackage

### src/svt_stream_if.sv
// Valid/ready item channel with source and sink modports.
`timescale 1ns / 1ps

interface svt_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### src/svt_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
`timescale 1ns / 1ps

module svt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

### src/sorted_value_table.sv
// Top level of the sorted value table: sequencer, search and shift control.
`timescale 1ns / 1ps

// Holds up to CAPACITY signed 32-bit values in ascending order in one RAM
// with a registered read port. Each request (insert, remove, lookup) runs
// alone. It is accepted in the idle cycle. A bisection search over the
// stored entries follows: each probe has a read step and a compare step,
// and one more search step ends it when the window closes without a
// match. A dispatch step comes next. Unless the table is full, insert
// then moves every entry from the insertion position up by one, with a
// read and a write step per entry, and then stores the key. If the key
// was found, remove moves the entries above the match down, with a read
// and a write step per entry, and then updates the count. A last step
// loads the result register once the output is free. A new request is
// taken once the previous one has reached the result register, even if
// that result is not yet taken. Unused request kind 3 acts as a lookup.
// position and entry_count carry the low 7 bits of the index and count.
module sorted_value_table
    import svt_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    svt_stream_if.sink   req,
    svt_stream_if.source rsp
);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int IDX_W  = $clog2(CAPACITY);
    localparam int WIDE_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    state_t                  state_reg, state_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [CNT_W-1:0]        lo_reg, lo_next;
    logic [CNT_W-1:0]        hi_reg, hi_next;
    logic [CNT_W-1:0]        mid_reg, mid_next;
    logic [CNT_W-1:0]        i_reg, i_next;
    logic [CNT_W-1:0]        pos_reg, pos_next;
    logic                    hit_reg, hit_next;
    logic [REQ_W-1:0]        kind_reg, kind_next;
    logic signed [KEY_W-1:0] key_reg, key_next;
    status_t                 status_reg, status_next;
    logic                    out_valid_reg, out_valid_next;
    rsp_item_t               out_data_reg, out_data_next;

    logic                    ram_we;
    logic [IDX_W-1:0]        ram_waddr;
    logic [KEY_W-1:0]        ram_wdata;
    logic [IDX_W-1:0]        ram_raddr;
    logic [KEY_W-1:0]        ram_rdata;
    logic signed [KEY_W-1:0] probe_value;

    logic [CNT_W:0]          lo_hi_sum;
    logic [CNT_W-1:0]        mid_calc;
    logic [CNT_W:0]          i_plus_one;
    logic [WIDE_W-1:0]       pos_wide;
    logic [WIDE_W-1:0]       count_wide;
    logic                    out_load;

    svt_ram #(
        .WIDTH (KEY_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign probe_value = $signed(ram_rdata);
    assign lo_hi_sum   = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid_calc    = lo_hi_sum[CNT_W:1];
    assign i_plus_one  = {1'b0, i_reg} + {{CNT_W{1'b0}}, 1'b1};
    assign pos_wide    = WIDE_W'(pos_reg);
    assign count_wide  = WIDE_W'(count_reg);

    assign req.ready = (state_reg == S_IDLE);
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        mid_reg      <= mid_next;
        i_reg        <= i_next;
        pos_reg      <= pos_next;
        hit_reg      <= hit_next;
        kind_reg     <= kind_next;
        key_reg      <= key_next;
        status_reg   <= status_next;
        out_data_reg <= out_data_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        i_next         = i_reg;
        pos_next       = pos_reg;
        hit_next       = hit_reg;
        kind_next      = kind_reg;
        key_next       = key_reg;
        status_next    = status_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_load       = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = i_reg[IDX_W-1:0];
        ram_wdata      = ram_rdata;
        ram_raddr      = mid_calc[IDX_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    kind_next  = req.data.req_type;
                    key_next   = req.data.key_value;
                    lo_next    = '0;
                    hi_next    = count_reg;
                    hit_next   = 1'b0;
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                if (lo_reg < hi_reg)
                begin
                    mid_next   = mid_calc;
                    state_next = S_COMPARE;
                end
                else
                begin
                    pos_next   = lo_reg;
                    state_next = S_ACT;
                end
            end
            S_COMPARE:
            begin
                priority if (probe_value == key_reg)
                begin
                    hit_next   = 1'b1;
                    pos_next   = mid_reg;
                    state_next = S_ACT;
                end
                else if (probe_value > key_reg)
                begin
                    hi_next    = mid_reg;
                    state_next = S_SEARCH;
                end
                else
                begin
                    lo_next    = mid_reg + 1'b1;
                    state_next = S_SEARCH;
                end
            end
            S_ACT:
            begin
                unique case (kind_reg)
                    REQ_INSERT:
                    begin
                        if (count_reg >= CNT_W'(CAPACITY))
                        begin
                            status_next = ST_FULL;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            status_next = ST_DONE;
                            i_next      = count_reg;
                            state_next  = S_INS_RD;
                        end
                    end
                    REQ_REMOVE:
                    begin
                        if (!hit_reg)
                        begin
                            status_next = ST_NOT_FOUND;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            status_next = ST_DONE;
                            i_next      = pos_reg;
                            state_next  = S_REM_RD;
                        end
                    end
                    default:
                    begin
                        status_next = hit_reg ? ST_DONE : ST_NOT_FOUND;
                        state_next  = S_DONE;
                    end
                endcase
            end
            S_INS_RD:
            begin
                if (i_reg > pos_reg)
                begin
                    ram_raddr  = IDX_W'(i_reg - 1'b1);
                    state_next = S_INS_WR;
                end
                else
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = pos_reg[IDX_W-1:0];
                    ram_wdata  = key_reg;
                    count_next = count_reg + 1'b1;
                    state_next = S_DONE;
                end
            end
            S_INS_WR:
            begin
                ram_we     = 1'b1;
                i_next     = i_reg - 1'b1;
                state_next = S_INS_RD;
            end
            S_REM_RD:
            begin
                if (i_plus_one < {1'b0, count_reg})
                begin
                    ram_raddr  = i_plus_one[IDX_W-1:0];
                    state_next = S_REM_WR;
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                    state_next = S_DONE;
                end
            end
            S_REM_WR:
            begin
                ram_we     = 1'b1;
                i_next     = i_plus_one[CNT_W-1:0];
                state_next = S_REM_RD;
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_load                  = 1'b1;
                    out_valid_next            = 1'b1;
                    out_data_next.status      = status_reg;
                    out_data_next.found       = hit_reg;
                    out_data_next.position    = pos_wide[POS_W-1:0];
                    out_data_next.entry_count = count_wide[POS_W-1:0];
                    state_next                = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_full_only_at_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        out_load && status_reg == ST_FULL |-> count_reg == CNT_W'(CAPACITY))
        else $error("full status while table not full");

    a_search_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_COMPARE |-> lo_reg <= mid_reg && mid_reg < hi_reg)
        else $error("probe outside search window");

    a_found_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> !(rsp.data.found && rsp.data.status == ST_NOT_FOUND))
        else $error("found flag with not-found status");

    a_remove_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_REM_WR |-> i_plus_one < {1'b0, count_reg})
        else $error("remove shift beyond stored entries");
`endif
endmodule

### verif/sorted_value_table_tb.sv
// Testbench for sorted_value_table: directed and random requests checked against a table model.
`timescale 1ns / 1ps

module sorted_value_table_tb;
    import svt_pkg::*;

    localparam int TABLE_DEPTH = 64;
    localparam int MAX_SHOWN = 10;
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;

    logic clk = 1'b0;
    logic rst_n;

    svt_stream_if #(.payload_t(req_item_t)) req_if ();
    svt_stream_if #(.payload_t(rsp_item_t)) rsp_if ();

    sorted_value_table #(.CAPACITY(TABLE_DEPTH)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    logic signed [KEY_W-1:0] stored_keys [TABLE_DEPTH];
    int                      stored_count = 0;
    rsp_item_t               pending_results [$];
    int                      fault_count = 0;
    int                      shown_count = 0;
    bit                      steady_flow = 1'b0;
    int                      stall_left = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        if (steady_flow)
            return 0;
        r = $urandom_range(99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(3, 1);
        if (r < 97)
            return $urandom_range(10, 4);
        return $urandom_range(60, 20);
    endfunction

    // bisection with early exit on the first equal probe, as the block searches
    function automatic rsp_item_t predict_request(input logic [REQ_W-1:0] kind,
                                                  input logic signed [KEY_W-1:0] key);
        int        lo;
        int        hi;
        int        mid;
        int        pos;
        bit        hit;
        status_t   st;
        rsp_item_t res;
        lo  = 0;
        hi  = stored_count;
        hit = 1'b0;
        pos = 0;
        while (lo < hi && !hit)
        begin
            mid = (lo + hi) / 2;
            if (stored_keys[mid] == key)
            begin
                hit = 1'b1;
                pos = mid;
            end
            else if (stored_keys[mid] > key)
                hi = mid;
            else
                lo = mid + 1;
        end
        if (!hit)
            pos = lo;
        st = ST_DONE;
        case (kind)
            REQ_INSERT:
                if (stored_count >= TABLE_DEPTH)
                    st = ST_FULL;
                else
                begin
                    for (int i = stored_count; i > pos; i--)
                        stored_keys[i] = stored_keys[i-1];
                    stored_keys[pos] = key;
                    stored_count++;
                end
            REQ_REMOVE:
                if (!hit)
                    st = ST_NOT_FOUND;
                else
                begin
                    for (int i = pos; i + 1 < stored_count; i++)
                        stored_keys[i] = stored_keys[i+1];
                    stored_count--;
                end
            default:
                st = hit ? ST_DONE : ST_NOT_FOUND;
        endcase
        res.status      = st;
        res.found       = hit;
        res.position    = pos[POS_W-1:0];
        res.entry_count = stored_count[POS_W-1:0];
        return res;
    endfunction

    function automatic logic signed [KEY_W-1:0] pick_key(input int stored_share);
        int r;
        int v;
        r = $urandom_range(99);
        if (stored_count > 0 && r < stored_share)
            return stored_keys[$urandom_range(stored_count - 1)];
        r = $urandom_range(99);
        if (r < 45)
        begin
            v = $urandom_range(15);
            return v - 8;
        end
        if (r < 65)
        begin
            case ($urandom_range(5))
                0: return KEY_MIN;
                1: return KEY_MAX;
                2: return KEY_MIN + 1;
                3: return KEY_MAX - 1;
                4: return 0;
                default: return -1;
            endcase
        end
        return $urandom();
    endfunction

    function automatic logic [REQ_W-1:0] pick_kind(input int insert_share);
        int r;
        r = $urandom_range(99);
        if (r < insert_share)
            return REQ_INSERT;
        r = $urandom_range(99);
        if (r < 55)
            return REQ_REMOVE;
        if (r < 93)
            return REQ_LOOKUP;
        return REQ_UNUSED;
    endfunction

    task automatic send_request(input logic [REQ_W-1:0] kind,
                                input logic signed [KEY_W-1:0] key);
        int        gap;
        req_item_t item;
        gap = pick_gap();
        item.req_type  = kind;
        item.key_value = key;
        if (gap > 0)
        begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.data  <= item;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        pending_results.push_back(predict_request(kind, key));
    endtask

    task automatic test_directed();
        send_request(REQ_LOOKUP, 0);
        send_request(REQ_REMOVE, 5);
        send_request(REQ_UNUSED, 0);
        send_request(REQ_INSERT, KEY_MAX);
        send_request(REQ_INSERT, KEY_MIN);
        send_request(REQ_INSERT, 0);
        send_request(REQ_INSERT, -1);
        send_request(REQ_INSERT, 1);
        send_request(REQ_INSERT, 0);
        send_request(REQ_INSERT, 0);
        send_request(REQ_LOOKUP, 0);
        send_request(REQ_LOOKUP, KEY_MIN);
        send_request(REQ_LOOKUP, KEY_MAX);
        send_request(REQ_LOOKUP, 2);
        send_request(REQ_LOOKUP, -2);
        send_request(REQ_UNUSED, 1);
        send_request(REQ_UNUSED, 7);
        send_request(REQ_REMOVE, 0);
        send_request(REQ_REMOVE, KEY_MIN);
        send_request(REQ_REMOVE, KEY_MAX);
        send_request(REQ_REMOVE, 2);
        send_request(REQ_REMOVE, 0);
        send_request(REQ_REMOVE, 0);
        send_request(REQ_REMOVE, 0);
    endtask

    // insert share follows the fill level so the table wanders over its whole range
    task automatic test_random_mix(input int n);
        int share;
        repeat (n)
        begin
            if (stored_count < 16)
                share = 70;
            else if (stored_count > 48)
                share = 35;
            else
                share = 50;
            send_request(pick_kind(share), pick_key(40));
        end
    endtask

    task automatic test_fill_and_drain(input int rounds);
        repeat (rounds)
        begin
            while (stored_count < TABLE_DEPTH)
                send_request(REQ_INSERT, pick_key(20));
            repeat (12)
                send_request($urandom_range(1) ? REQ_INSERT : REQ_LOOKUP, pick_key(30));
            while (stored_count > 0)
                send_request($urandom_range(4) != 0 ? REQ_REMOVE : REQ_LOOKUP, pick_key(85));
        end
    endtask

    task automatic test_wide_keys(input int n);
        repeat (n)
            send_request(pick_kind(stored_count < 40 ? 55 : 40),
                         $urandom_range(1) ? $urandom() : pick_key(50));
    endtask

    task automatic test_back_to_back(input int n);
        steady_flow = 1'b1;
        test_random_mix(n);
        steady_flow = 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            rsp_if.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end
        else
        begin
            rsp_if.ready <= 1'b1;
            stall_left   <= pick_gap();
        end
    end

    always @(posedge clk)
    begin : check_results
        rsp_item_t want;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            if (pending_results.size() == 0)
            begin
                fault_count++;
                if (shown_count < MAX_SHOWN)
                begin
                    shown_count++;
                    $display("unexpected result at %0t: status=%0d position=%0d",
                             $realtime, rsp_if.data.status, rsp_if.data.position);
                end
            end
            else
            begin
                want = pending_results.pop_front();
                if (rsp_if.data.status !== want.status || rsp_if.data.found !== want.found
                    || rsp_if.data.position !== want.position
                    || rsp_if.data.entry_count !== want.entry_count)
                begin
                    fault_count++;
                    if (shown_count < MAX_SHOWN)
                    begin
                        shown_count++;
                        $display("mismatch at %0t: expected st=%0d f=%0d pos=%0d cnt=%0d",
                                 $realtime, want.status, want.found, want.position,
                                 want.entry_count);
                        $display("                   actual st=%0d f=%0d pos=%0d cnt=%0d",
                                 rsp_if.data.status, rsp_if.data.found,
                                 rsp_if.data.position, rsp_if.data.entry_count);
                    end
                end
            end
        end
    end

    initial
    begin
        #25_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin : run_tests
        int waited;
        rst_n        = 1'b0;
        req_if.valid = 1'b0;
        req_if.data  = '0;
        waited       = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_mix(700);
        test_fill_and_drain(2);
        test_wide_keys(400);
        test_back_to_back(150);
        req_if.valid <= 1'b0;
        while (pending_results.size() > 0 && waited < 100000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (200) @(posedge clk);
        fault_count += pending_results.size();
        if (fault_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

### filelist.f
src/svt_pkg.sv
src/svt_stream_if.sv
src/svt_ram.sv
src/sorted_value_table.sv
verif/sorted_value_table_tb.sv
